// File: rtl/core/ccx_pkg.sv
// ----------------------------------------------------------------------------
// ccx_pkg
// shared types, constants and the quarter-round step for the stream xor block
// ----------------------------------------------------------------------------
package ccx_pkg;

   localparam int unsigned DoubleRounds = 10;
   localparam int unsigned QrSteps      = DoubleRounds * 8;
   localparam int unsigned StepW        = $clog2(QrSteps + 1);
   localparam int unsigned CsrIdxW      = 3;
   localparam int unsigned CsrDataW     = 64;
   localparam int unsigned QueueDepth   = 2;

   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   typedef enum logic [2:0] {
      CSR_KEY01   = 3'd0,
      CSR_KEY23   = 3'd1,
      CSR_KEY45   = 3'd2,
      CSR_KEY67   = 3'd3,
      CSR_NONCE01 = 3'd4,
      CSR_NONCE2  = 3'd5,
      CSR_CTR     = 3'd6
   } csr_idx_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_ROUND = 2'd1,
      BK_FEED  = 2'd2,
      BK_OUT   = 2'd3
   } bk_state_type;

   // front to back: classified byte
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       new_block;
      logic       load_ctr;
      logic [5:0] pos;
   } job_type;

   typedef logic [31:0] word16_type [16];

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction

   // quarter-round on four words, returned packed a,b,c,d (a in msbs)
   function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] ta, tb, tc, td;
      ta = a + b; td = rotl(d ^ ta, 16);
      tc = c + td; tb = rotl(b ^ tc, 12);
      ta = ta + tb; td = rotl(td ^ ta, 8);
      tc = tc + td; tb = rotl(tb ^ tc, 7);
      qround = {ta, tb, tc, td};
   endfunction

endpackage

// File: rtl/core/ccx_stream_if.sv
// ----------------------------------------------------------------------------
// ccx_stream_if
// valid/ready channel carrying one byte and a last flag
// ----------------------------------------------------------------------------
interface ccx_stream_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic       last;
   modport source (output valid, output data, output last, input ready);
   modport sink   (input valid, input data, input last, output ready);
endinterface

// File: rtl/core/ccx_front.sv
// ----------------------------------------------------------------------------
// ccx_front
// accepts bytes, tracks position and message start, queues classified jobs
// ----------------------------------------------------------------------------
module ccx_front
   import ccx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  logic [7:0] in_data,
   input  logic    in_last,
   output logic    job_valid,
   input  logic    job_take,
   output job_type job
);
   localparam int unsigned PtrW = $clog2(QueueDepth);

   job_type              q_ff [QueueDepth];
   logic [PtrW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]        cnt_ff, cnt_in;
   logic [5:0]           pos_ff, pos_in;
   logic                 fresh_ff, fresh_in;
   logic                 push;
   job_type              nj;

   assign in_ready  = (cnt_ff != (PtrW+1)'(QueueDepth));
   assign push      = in_valid && in_ready;
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rd_ff];

   always_comb begin
      nj.data      = in_data;
      nj.last      = in_last;
      nj.new_block = (pos_ff == 6'd0);
      nj.load_ctr  = fresh_ff;
      nj.pos       = pos_ff;
      pos_in   = pos_ff;
      fresh_in = fresh_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      cnt_in   = cnt_ff;
      if (push) begin
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd0) fresh_in = 1'b0;
         if (in_last) begin
            pos_in   = 6'd0;
            fresh_in = 1'b1;
         end
         wr_in = (wr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (job_take && job_valid)
         rd_in = (rd_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(job_take && job_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fresh_ff <= 1'b1;
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         fresh_ff <= fresh_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         cnt_ff   <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= nj;
   end
endmodule

// File: rtl/core/ccx_back.sv
// ----------------------------------------------------------------------------
// ccx_back
// keystream block generator (one quarter-round per cycle) and output stage
// ----------------------------------------------------------------------------
module ccx_back
   import ccx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [255:0]  key,
   input  logic [95:0]   nonce,
   input  logic [31:0]   ctr_start,
   input  logic          job_valid,
   output logic          job_take,
   input  job_type       job,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_data,
   output logic          out_last
);
   bk_state_type  st_ff, st_in;
   word16_type    w_ff, w_in, init_ff, init_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [31:0]   ctr_ff, ctr_in;
   logic          ov_ff, ov_in;
   logic [7:0]    od_ff, od_in;
   logic          ol_ff, ol_in;
   logic [2:0]    qsel;
   logic [3:0]    ia, ib, ic, id;
   logic [127:0]  qr;
   logic [31:0]   kw;
   logic [7:0]    ks;
   logic          out_free;

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_last  = ol_ff;
   assign out_free  = !ov_ff || out_ready;

   // quarter-round index pattern: columns then diagonals
   assign qsel = step_ff[2:0];
   always_comb begin
      ia = {2'b00, qsel[1:0]};
      ib = 4'd4 + {2'b00, qsel[1:0]};
      ic = 4'd8 + {2'b00, qsel[1:0]};
      id = 4'd12 + {2'b00, qsel[1:0]};
      if (qsel[2]) begin
         ib = 4'd4  + {2'b00, qsel[1:0] + 2'd1};
         ic = 4'd8  + {2'b00, qsel[1:0] + 2'd2};
         id = 4'd12 + {2'b00, qsel[1:0] + 2'd3};
      end
   end
   assign qr = qround(w_ff[ia], w_ff[ib], w_ff[ic], w_ff[id]);

   assign kw = w_ff[job.pos[5:2]];
   assign ks = kw[{job.pos[1:0], 3'b000} +: 8];

   always_comb begin
      st_in   = st_ff;
      w_in    = w_ff;
      init_in = init_ff;
      step_in = step_ff;
      ctr_in  = ctr_ff;
      ov_in   = ov_ff && !out_ready;
      od_in   = od_ff;
      ol_in   = ol_ff;
      job_take = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            if (job_valid) begin
               if (job.new_block) begin
                  init_in[0] = Sigma0; init_in[1] = Sigma1;
                  init_in[2] = Sigma2; init_in[3] = Sigma3;
                  for (int i = 0; i < 8; i++) init_in[4+i] = key[32*i +: 32];
                  init_in[12] = job.load_ctr ? ctr_start : ctr_ff;
                  init_in[13] = nonce[31:0];
                  init_in[14] = nonce[63:32];
                  init_in[15] = nonce[95:64];
                  ctr_in  = init_in[12];
                  w_in    = init_in;
                  step_in = '0;
                  st_in   = BK_ROUND;
               end else begin
                  st_in = BK_OUT;
               end
            end
         end
         BK_ROUND: begin
            w_in[ia] = qr[127:96];
            w_in[ib] = qr[95:64];
            w_in[ic] = qr[63:32];
            w_in[id] = qr[31:0];
            step_in  = step_ff + 1'b1;
            if (step_ff == StepW'(QrSteps - 1)) st_in = BK_FEED;
         end
         BK_FEED: begin
            for (int i = 0; i < 16; i++) w_in[i] = w_ff[i] + init_ff[i];
            st_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               job_take = 1'b1;
               ov_in    = 1'b1;
               od_in    = job.data ^ ks;
               ol_in    = job.last;
               if (job.pos == 6'd63) ctr_in = ctr_ff + 32'd1;
               // next byte goes back through idle, which reuses this block unless it starts a new one
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= BK_IDLE;
         ov_ff  <= 1'b0;
         ctr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         ov_ff  <= ov_in;
         ctr_ff <= ctr_in;
      end
      w_ff    <= w_in;
      init_ff <= init_in;
      step_ff <= step_in;
      od_ff   <= od_in;
      ol_ff   <= ol_in;
   end
endmodule

// File: rtl/core/chacha20_stream_xor_top.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor_top
// byte-serial chacha20 (96-bit nonce) encrypt/decrypt
// ----------------------------------------------------------------------------
// Each request carries one message byte; the response is that byte xored with
// the next keystream byte. Bytes inside a 64-byte block pass through a dispatch
// state, then the output register. The first byte of a block waits for the
// block generator: dispatch, 80 quarter-round steps (one quarter-round unit,
// one step per cycle), a feed-forward step and the output register. A
// two-entry queue sits between the request side and the generator. Write csr
// registers only while idle; counter_start is loaded at each message start.
module chacha20_stream_xor_top
   import ccx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   ccx_stream_if.sink          req,
   ccx_stream_if.source        rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_idx,
   input  logic [CsrDataW-1:0] csr_wdata
);
   // configuration registers
   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, non01_ff;
   logic [31:0] non2_ff, ctr_ff;

   logic    job_valid, job_take;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff <= '0; key23_ff <= '0; key45_ff <= '0; key67_ff <= '0;
         non01_ff <= '0; non2_ff <= '0; ctr_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_KEY01:   key01_ff <= csr_wdata;
            CSR_KEY23:   key23_ff <= csr_wdata;
            CSR_KEY45:   key45_ff <= csr_wdata;
            CSR_KEY67:   key67_ff <= csr_wdata;
            CSR_NONCE01: non01_ff <= csr_wdata;
            CSR_NONCE2:  non2_ff  <= csr_wdata[31:0];
            CSR_CTR:     ctr_ff   <= csr_wdata[31:0];
            default: ;   // out-of-range index ignored
         endcase
      end
   end

   // front: position tracking and job queue
   ccx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req.data),
      .in_last   (req.last),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job)
   );

   // back: keystream generation and response register
   ccx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       ({key67_ff, key45_ff, key23_ff, key01_ff}),
      .nonce     ({non2_ff, non01_ff}),
      .ctr_start (ctr_ff),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data),
      .out_last  (rsp.last)
   );
endmodule
